[rtl/sfr7_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr7_pkg
// Shared types, register indexes and the seven-segment symbol table for the
// status frame receiver.
// ----------------------------------------------------------------------------
package sfr7_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 4'd1;

  localparam logic [7:0] SYNC_RESET    = 8'hA5;
  localparam logic [3:0] LEN_RESET     = 4'd5;
  localparam logic [3:0] LEN_MIN       = 4'd5;
  localparam logic [3:0] LEN_MAX       = 4'd8;
  localparam int unsigned HEAD_DEPTH   = 4;
  localparam logic [7:0] DISPLAY_MASK  = 8'h10;

  localparam int unsigned NUM_SYMBOLS  = 19;
  localparam logic [4:0] SYM_BLANK     = 5'd10;

  typedef logic [7:0] seg_table_t [NUM_SYMBOLS];

  localparam seg_table_t SEG_PATTERNS = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
    8'h00, 8'h40, 8'h77, 8'h79, 8'h71, 8'h76, 8'h38, 8'h31, 8'h50
  };

  typedef struct packed {
    logic       frame_ok;
    logic [7:0] status_byte;
    logic [4:0] symbol_0;
    logic       dot_0;
    logic [4:0] symbol_1;
    logic       dot_1;
    logic [4:0] symbol_2;
    logic       dot_2;
    logic       bad_symbol;
  } result_t;

  // Index of the 7-bit pattern in the table; blank with known cleared if absent.
  function automatic logic [5:0] seg_lookup(input logic [7:0] pattern);
    logic [4:0] sym;
    logic       known;
    sym   = SYM_BLANK;
    known = 1'b0;
    for (int k = NUM_SYMBOLS - 1; k >= 0; k--) begin
      if (SEG_PATTERNS[k] == {1'b0, pattern[6:0]}) begin
        sym   = 5'(k);
        known = 1'b1;
      end
    end
    return {known, sym};
  endfunction

endpackage
`default_nettype wire

[rtl/status_frame_receiver_7seg_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_frame_receiver_7seg_decode
// Sync-byte frame receiver with additive checksum and seven-segment decode.
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle unless stalled. While hunting it waits
// for sync_byte, then collects frame_length bytes (clamped to 5..8), the last
// one being the checksum of the 8-bit sum of the others. The checksum byte
// produces one result, taken from the running-sum and head byte registers
// through the decode logic into the output register or second entry; other
// bytes produce nothing. A two-entry output buffer keeps input flowing while
// a result waits; input stalls only when both entries are full. The config
// port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module status_frame_receiver_7seg_decode
  import sfr7_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_frame_ok,
  output logic [7:0]                out_status_byte,
  output logic [4:0]                out_symbol_0,
  output logic                      out_dot_0,
  output logic [4:0]                out_symbol_1,
  output logic                      out_dot_1,
  output logic [4:0]                out_symbol_2,
  output logic                      out_dot_2,
  output logic                      out_bad_symbol,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic [7:0] sync_r;
  logic [3:0] len_r;
  logic       receiving_r, receiving_nxt;
  logic [3:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] head_r [HEAD_DEPTH];

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  result_t    out_r, skid_r, frame_res;

  logic       in_fire, out_fire, is_cksum, produce;
  logic [3:0] eff_len;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  assign eff_len   = (len_r < LEN_MIN) ? LEN_MIN : ((len_r > LEN_MAX) ? LEN_MAX : len_r);
  assign is_cksum  = !((5'(count_r) + 5'd1) < 5'(eff_len));
  assign produce   = in_fire && receiving_r && is_cksum;

  sfr7_frame_decode u_decode (
    .head_0    (head_r[0]),
    .head_1    (head_r[1]),
    .head_2    (head_r[2]),
    .head_3    (head_r[3]),
    .sum_match (sum_r == in_rx_byte),
    .result    (frame_res)
  );

  always_comb begin
    receiving_nxt = receiving_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    if (in_fire) begin
      if (!receiving_r) begin
        if (in_rx_byte == sync_r) begin
          receiving_nxt = 1'b1;
          count_nxt     = 4'd0;
          sum_nxt       = 8'h00;
        end
      end else if (is_cksum) begin
        receiving_nxt = 1'b0;
        count_nxt     = 4'd0;
        sum_nxt       = 8'h00;
      end else begin
        count_nxt = count_r + 4'd1;
        sum_nxt   = sum_r + in_rx_byte;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r || out_fire) begin
        out_valid_nxt = 1'b1;
      end else begin
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r       <= SYNC_RESET;
      len_r        <= LEN_RESET;
      receiving_r  <= 1'b0;
      count_r      <= 4'd0;
      sum_r        <= 8'h00;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC_BYTE:    sync_r <= cfg_data;
          CFG_FRAME_LENGTH: len_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      receiving_r  <= receiving_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload: head bytes and result buffers
  always_ff @(posedge clk) begin
    if (in_fire && receiving_r && !is_cksum && (count_r < 4'(HEAD_DEPTH))) begin
      head_r[count_r[1:0]] <= in_rx_byte;
    end
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (produce) begin
      if (!out_valid_r || out_fire) begin
        out_r <= frame_res;
      end else begin
        skid_r <= frame_res;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_ok    = out_r.frame_ok;
  assign out_status_byte = out_r.status_byte;
  assign out_symbol_0    = out_r.symbol_0;
  assign out_dot_0       = out_r.dot_0;
  assign out_symbol_1    = out_r.symbol_1;
  assign out_dot_1       = out_r.dot_1;
  assign out_symbol_2    = out_r.symbol_2;
  assign out_dot_2       = out_r.dot_2;
  assign out_bad_symbol  = out_r.bad_symbol;

endmodule
`default_nettype wire

[rtl/sfr7_frame_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr7_frame_decode
// Builds the frame result from the stored head bytes and checksum verdict:
// status byte, three decoded seven-segment symbols, dots and the bad flag.
// ----------------------------------------------------------------------------
module sfr7_frame_decode
  import sfr7_pkg::*;
(
  input  wire logic [7:0] head_0,
  input  wire logic [7:0] head_1,
  input  wire logic [7:0] head_2,
  input  wire logic [7:0] head_3,
  input  wire logic       sum_match,
  output result_t         result
);

  logic [5:0] lk_0, lk_1, lk_2;
  logic       show;

  assign lk_0 = seg_lookup(head_0);
  assign lk_1 = seg_lookup(head_1);
  assign lk_2 = seg_lookup(head_2);
  assign show = sum_match && ((head_3 & DISPLAY_MASK) != 8'h00);

  always_comb begin
    result.frame_ok    = sum_match;
    result.status_byte = head_3;
    result.symbol_0    = SYM_BLANK;
    result.dot_0       = 1'b0;
    result.symbol_1    = SYM_BLANK;
    result.dot_1       = 1'b0;
    result.symbol_2    = SYM_BLANK;
    result.dot_2       = 1'b0;
    result.bad_symbol  = 1'b0;
    if (show) begin
      result.symbol_0   = lk_0[4:0];
      result.dot_0      = head_0[7];
      result.symbol_1   = lk_1[4:0];
      result.dot_1      = head_1[7];
      result.symbol_2   = lk_2[4:0];
      result.dot_2      = head_2[7];
      result.bad_symbol = !(lk_0[5] && lk_1[5] && lk_2[5]);
    end
  end

endmodule
`default_nettype wire
